// ===== rtl/mdsq_pkg.sv =====
`default_nettype none
package mdsq_pkg;

    // field widths
    localparam int IN_W    = 32;
    localparam int SCL_W   = 31;
    localparam int IN_DW   = 384;
    localparam int OUT_DW  = 320;

    // square root units: result bits, one bit resolved per stage
    localparam int SQ_NB   = 31;
    localparam int QR_NB   = 25;

    // divider: numerator magnitude shifted by 16, divisor 2r, quotient bits
    localparam int NUM_W   = 49;
    localparam int DEN_W   = 26;
    localparam int QUO_W   = 33;

    // pipeline depths
    localparam int LAT_SQ  = SQ_NB;
    localparam int LAT_QR  = QR_NB;
    localparam int LAT_DIV = QUO_W;

    localparam logic signed [34:0] ONE_Q16 = 35'sd65536;

    // quaternion branch
    typedef enum logic [1:0] {
        BR_X     = 2'd0,
        BR_Y     = 2'd1,
        BR_Z     = 2'd2,
        BR_TRACE = 2'd3
    } br_t;

    // signed saturation of a quotient magnitude
    function automatic logic [31:0] sat_quot(input logic [QUO_W-1:0] q,
                                             input logic ovf, input logic neg);
        logic [31:0] res;
        if (ovf)
        begin
            res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (!neg)
        begin
            res = (q > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end
        else
        begin
            res = (q > QUO_W'(32'h8000_0000)) ? 32'h8000_0000 : (~q[31:0]) + 32'd1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mdsq_isqrt.sv =====
`default_nettype none
module mdsq_isqrt import mdsq_pkg::*;
#(
    parameter int NB = SQ_NB
)
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [2*NB-1:0] din,
    output logic      [NB-1:0]   root
);
    localparam int W = 2 * NB;

    logic [W-1:0] v_reg   [NB];
    logic [W-1:0] res_reg [NB];

    // one result bit per stage, highest first
    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * (NB - 1 - k));
        logic [W-1:0] v_in;
        logic [W-1:0] r_in;
        logic [W-1:0] trial;
        logic [W-1:0] v_next;
        logic [W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign v_in = din;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next   = v_in;
                res_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]   <= v_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[NB-1][NB-1:0];

endmodule
`default_nettype wire

// ===== rtl/mdsq_div.sv =====
`default_nettype none
module mdsq_div import mdsq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic             neg,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quot,
    output logic                  ovf,
    output logic                  neg_out
);
    localparam int CW = DEN_W + QUO_W + 1;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W];
    logic             ovf_reg [QUO_W];
    logic             neg_reg [QUO_W];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic             ovf_in;
        logic             neg_in;
        logic [CW-1:0]    dsh;
        logic [NUM_W-1:0] rem_next;
        logic             qbit;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign neg_in = neg;
            // quotient of 2^33 or more saturates regardless of the low bits
            assign ovf_in = (CW'(num) >= (CW'(den) << QUO_W));
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        always_comb
        begin
            dsh = CW'(den_in) << (QUO_W - 1 - k);
            if (CW'(rem_in) >= dsh)
            begin
                rem_next = rem_in - dsh[NUM_W-1:0];
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
                qbit     = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                q_reg[k]   <= {q_in[QUO_W-2:0], qbit};
                ovf_reg[k] <= ovf_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign quot    = q_reg[QUO_W-1];
    assign ovf     = ovf_reg[QUO_W-1];
    assign neg_out = neg_reg[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/matrix_decompose_scale_quaternion.sv =====
// channel   dir  signals                          contents
// s_axis    in   s_tvalid s_tready s_tdata[383:0] 3x3 entries and translation
// m_axis    out  m_tvalid m_tready m_tdata[319:0] position, scale, quaternion
//                m_tuser[0:0]                     degenerate flag
//
// one transform accepted per cycle unless stalled; a request passes through the stages
// input, square/select, sum, 25-stage root, 33-stage divider and output to its result
// reset clears only the valid bits; payload registers are not reset
// a stall at m_tready freezes the whole pipeline; s_tready follows it
`default_nettype none
module matrix_decompose_scale_quaternion import mdsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // c0r0 c0r1 c0r2 c1r0 c1r1 c1r2 c2r0 c2r1 c2r2 trans_x trans_y trans_z
    input  wire logic [IN_DW-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // pos_x pos_y pos_z scale_x scale_y scale_z quat_w quat_x quat_y quat_z, 3 zero bits
    output logic [OUT_DW-1:0]      m_tdata,
    // degenerate
    output logic [0:0]             m_tuser
);
    localparam int NV     = 3 + LAT_QR + LAT_DIV;
    localparam int LAT_SD = LAT_QR + LAT_DIV;
    localparam int LAT_SX = LAT_SD - LAT_SQ;

    typedef struct packed {
        logic [2:0][IN_W-1:0] pos;
        br_t                  br;
        logic                 degen;
        logic [2:0]           ssat;
    } side_t;

    logic en;
    logic [NV-1:0] vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[NV-2:0], s_tvalid};
            m_tvalid <= vld_reg[NV-1];
        end
    end

    // input stage
    logic signed [IN_W-1:0] m_reg [12];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
            begin
                m_reg[i] <= s_tdata[i*IN_W +: IN_W];
            end
        end
    end

    // squares, root argument, branch and numerators
    logic [IN_W-1:0]        mg [9];
    logic signed [34:0]     a_tr, a_0, a_1, a_2, a_sel;
    logic signed [32:0]     s01, s20, s12, d12, d20, d01;
    logic signed [32:0]     n_sel [3];
    br_t                    br_sel;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            mg[i] = m_reg[i][IN_W-1] ? (~m_reg[i]) + 32'd1 : m_reg[i];
        end
        a_tr = ONE_Q16 + 35'(m_reg[0]) + 35'(m_reg[4]) + 35'(m_reg[8]);
        a_0  = ONE_Q16 + 35'(m_reg[0]) - 35'(m_reg[4]) - 35'(m_reg[8]);
        a_1  = ONE_Q16 + 35'(m_reg[4]) - 35'(m_reg[0]) - 35'(m_reg[8]);
        a_2  = ONE_Q16 + 35'(m_reg[8]) - 35'(m_reg[0]) - 35'(m_reg[4]);
        s01  = 33'(m_reg[1]) + 33'(m_reg[3]);
        s20  = 33'(m_reg[6]) + 33'(m_reg[2]);
        s12  = 33'(m_reg[5]) + 33'(m_reg[7]);
        d12  = 33'(m_reg[5]) - 33'(m_reg[7]);
        d20  = 33'(m_reg[6]) - 33'(m_reg[2]);
        d01  = 33'(m_reg[1]) - 33'(m_reg[3]);
        if (a_tr > 0)
        begin
            br_sel = BR_TRACE;
            a_sel  = a_tr;
            n_sel  = '{d12, d20, d01};
        end
        else if (m_reg[0] > m_reg[4] && m_reg[0] > m_reg[8])
        begin
            br_sel = BR_X;
            a_sel  = a_0;
            n_sel  = '{s01, s20, d12};
        end
        else if (m_reg[4] > m_reg[8])
        begin
            br_sel = BR_Y;
            a_sel  = a_1;
            n_sel  = '{s01, s12, d20};
        end
        else
        begin
            br_sel = BR_Z;
            a_sel  = a_2;
            n_sel  = '{s20, s12, d01};
        end
    end

    logic [63:0]            sq_reg [9];
    logic signed [34:0]     a_reg;
    logic signed [32:0]     n_reg [3];
    br_t                    br_reg;
    logic [2:0][IN_W-1:0]   pos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                sq_reg[i] <= mg[i] * mg[i];
            end
            a_reg   <= a_sel;
            n_reg   <= n_sel;
            br_reg  <= br_sel;
            pos_reg <= {m_reg[11], m_reg[10], m_reg[9]};
        end
    end

    // column sums with saturation, root argument, numerator magnitudes
    logic [63:0]      csum1 [3];
    logic [63:0]      csum2 [3];
    logic [2:0]       csat;
    logic [NUM_W-1:0] nmag [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            csum1[c] = sq_reg[3*c] + sq_reg[3*c+1];
            csum2[c] = csum1[c] + sq_reg[3*c+2];
            csat[c]  = (sq_reg[3*c][63:62] != 2'b00) || (sq_reg[3*c+1][63:62] != 2'b00) ||
                       (sq_reg[3*c+2][63:62] != 2'b00) || (csum1[c][63:62] != 2'b00) ||
                       (csum2[c][63:62] != 2'b00);
        end
        for (int i = 0; i < 3; i++)
        begin
            nmag[i] = {(n_reg[i][32] ? 33'(-n_reg[i]) : 33'(n_reg[i])), 16'h0000};
        end
    end

    logic [2*SQ_NB-1:0] ssum_reg [3];
    logic [2*QR_NB-1:0] rad_reg;
    logic [NUM_W-1:0]   nmag_reg [3];
    logic [2:0]         nneg_reg;
    side_t              side_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ssum_reg[c] <= csum2[c][2*SQ_NB-1:0];
                nmag_reg[c] <= nmag[c];
                nneg_reg[c] <= n_reg[c][32];
            end
            rad_reg          <= {a_reg[33:0], 16'h0000};
            side_c_reg.pos   <= pos_reg;
            side_c_reg.br    <= br_reg;
            side_c_reg.degen <= (a_reg <= 0);
            side_c_reg.ssat  <= csat;
        end
    end

    // square roots
    logic [SQ_NB-1:0] scl_root [3];
    logic [QR_NB-1:0] q_root;

    for (genvar c = 0; c < 3; c++)
    begin : g_scale
        mdsq_isqrt #(.NB(SQ_NB)) u_sqrt (
            .clk  (clk),
            .en   (en),
            .din  (ssum_reg[c]),
            .root (scl_root[c])
        );
    end

    mdsq_isqrt #(.NB(QR_NB)) u_qsqrt (
        .clk  (clk),
        .en   (en),
        .din  (rad_reg),
        .root (q_root)
    );

    // numerators wait for the root
    logic [NUM_W-1:0] nd_reg  [LAT_QR][3];
    logic [2:0]       ngd_reg [LAT_QR];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0]  <= nmag_reg;
            ngd_reg[0] <= nneg_reg;
            for (int i = 1; i < LAT_QR; i++)
            begin
                nd_reg[i]  <= nd_reg[i-1];
                ngd_reg[i] <= ngd_reg[i-1];
            end
        end
    end

    // dividers
    logic [QUO_W-1:0] quot [3];
    logic [2:0]       qovf;
    logic [2:0]       qneg;

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        mdsq_div u_div (
            .clk     (clk),
            .en      (en),
            .num     (nd_reg[LAT_QR-1][c]),
            .neg     (ngd_reg[LAT_QR-1][c]),
            .den     ({q_root, 1'b0}),
            .quot    (quot[c]),
            .ovf     (qovf[c]),
            .neg_out (qneg[c])
        );
    end

    // side data, scale results and root through the remaining depth
    side_t            side_reg [LAT_SD];
    logic [SQ_NB-1:0] sx_reg   [LAT_SX][3];
    logic [QR_NB-1:0] rd_reg   [LAT_DIV];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_c_reg;
            for (int i = 1; i < LAT_SD; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            sx_reg[0] <= scl_root;
            for (int i = 1; i < LAT_SX; i++)
            begin
                sx_reg[i] <= sx_reg[i-1];
            end
            rd_reg[0] <= q_root;
            for (int i = 1; i < LAT_DIV; i++)
            begin
                rd_reg[i] <= rd_reg[i-1];
            end
        end
    end

    // result assembly
    side_t             sd;
    logic [31:0]       qv [3];
    logic [31:0]       dg;
    logic [31:0]       qw, qx, qy, qz;
    logic [SCL_W-1:0]  scl [3];

    always_comb
    begin
        sd = side_reg[LAT_SD-1];
        for (int c = 0; c < 3; c++)
        begin
            qv[c]  = sat_quot(quot[c], qovf[c], qneg[c]);
            scl[c] = sd.ssat[c] ? {SCL_W{1'b1}} : sx_reg[LAT_SX-1][c];
        end
        dg = 32'(rd_reg[LAT_DIV-1] >> 1);
        case (sd.br)
            BR_TRACE:
            begin
                qw = dg;    qx = qv[0]; qy = qv[1]; qz = qv[2];
            end
            BR_X:
            begin
                qw = qv[2]; qx = dg;    qy = qv[0]; qz = qv[1];
            end
            BR_Y:
            begin
                qw = qv[2]; qx = qv[0]; qy = dg;    qz = qv[1];
            end
            default:
            begin
                qw = qv[2]; qx = qv[0]; qy = qv[1]; qz = dg;
            end
        endcase
        if (sd.degen)
        begin
            qw = '0; qx = '0; qy = '0; qz = '0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {3'b000, qz, qy, qx, qw, scl[2], scl[1], scl[0],
                        sd.pos[2], sd.pos[1], sd.pos[0]};
            m_tuser <= sd.degen;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mdsq_check.sv =====
`default_nettype none
module mdsq_check import mdsq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic [IN_DW-1:0]  s_tdata,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_DW-1:0] m_tdata,
    input wire logic [0:0]        m_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // degenerate result carries a zero quaternion
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[316:189] == '0)
        else $error("degenerate result with nonzero quaternion");

    // input side moves with the output side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("request side ready mismatch");

    // padding stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[319:317] == 3'b000)
        else $error("nonzero padding");

    // accepted request carries known data
    a_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("request with unknown data");

endmodule

bind matrix_decompose_scale_quaternion mdsq_check u_mdsq_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
